// ===== rtl/lir_pkg.sv =====
// Shared types, constants and sample helpers for the linear-interpolation resampler.
// No dependencies; used by the lane and top-level modules and by the checker and testbench.
`default_nettype none

package lir_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int RATE_W      = 18;
    localparam int FC_W        = 28;
    localparam int OUT_RATE_W  = 16;
    localparam int PROD_W      = FC_W + OUT_RATE_W;
    localparam int TOTAL_W     = 32;
    localparam int CNT_W       = 5;
    localparam int CFG_IDX_W   = 2;

    localparam logic [OUT_RATE_W-1:0] OUT_RATE    = 16'd48000;
    localparam logic [RATE_W-1:0]     RATE_MIN    = 18'd4000;
    localparam logic [RATE_W-1:0]     RATE_MAX    = 18'd192000;
    localparam logic [RATE_W-1:0]     RATE_RESET  = 18'd48000;
    localparam logic [CNT_W-1:0]      MAX_RESULTS = 5'd26;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN_BIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd3;

    // 8-bit unsigned x becomes (x - 128) * 256: flip the sign bit, move to the top byte
    function automatic logic signed [SAMPLE_W-1:0] to_s16(input logic [SAMPLE_W-1:0] raw,
                                                          input logic sixteen);
        logic signed [SAMPLE_W-1:0] v;
        begin
            if (sixteen)
            begin
                v = raw;
            end
            else
            begin
                v = {~raw[7], raw[6:0], 8'h00};
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lir_lane.sv =====
// One interpolation lane: a + floor((b - a) * frac / 2^FRAC_BITS).
// Depends on lir_pkg for the sample width.
`default_nettype none

module lir_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] a,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] b,
    input  wire logic        [FRAC_BITS-1:0]         frac,
    output logic      signed [lir_pkg::SAMPLE_W-1:0] y
);

    localparam int DIFF_W = lir_pkg::SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    logic signed [DIFF_W-1:0] diff_s;
    logic signed [PROD_W-1:0] prod_s;
    logic signed [PROD_W-1:0] shr_s;
    logic signed [DIFF_W-1:0] sum_s;

    always_comb
    begin
        diff_s = {b[lir_pkg::SAMPLE_W-1], b} - {a[lir_pkg::SAMPLE_W-1], a};
        prod_s = diff_s * $signed({1'b0, frac});
        // arithmetic shift floors negative products
        shr_s  = prod_s >>> FRAC_BITS;
        sum_s  = {a[lir_pkg::SAMPLE_W-1], a} + shr_s[DIFF_W-1:0];
        y      = sum_s[lir_pkg::SAMPLE_W-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/lir_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the output total.
// Depends on lir_pkg only through the instantiating module's widths.
`default_nettype none

module lir_div #(
    parameter int DIVIDEND_W = 44,
    parameter int DIVISOR_W  = 18
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic      [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  q_bit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;

        rem_sh  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        q_bit   = (rem_sh >= {1'b0, dvs_reg});

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], q_bit};
            rem_next = q_bit ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/linear_interp_resampler_48k_top.sv =====
// Top level of the 48 kHz linear-interpolation resampler: sequencer, two lanes, output merge.
// Depends on lir_pkg, lir_lane and lir_div.
//
//   channel  signals                                   direction  word
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in         one register write
//   in       in_valid/in_ready, left_raw, right_raw    in         one source frame
//   out      out_valid/out_ready, left_out, right_out,
//            run_last, clip_done                       out        one 48 kHz stereo frame
//
// First frame of a clip: the step by reciprocal multiply in S_DIVS, then the output total
// on the one-bit-per-cycle divider in S_DIVT; then as for any frame.
// Any frame: taken in S_IDLE, up to 26 results in S_EMA, then S_EMB on a clip's last frame.
// The output register lets a frame be accepted while the last result still waits.
// Reset is asynchronous; it leaves the block idle with 48 kHz stereo 16-bit settings.
// A stalled output holds the sequencer; cfg_ready is always high.
`default_nettype none

module linear_interp_resampler_48k_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [lir_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [lir_pkg::FC_W-1:0]               cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [lir_pkg::SAMPLE_W-1:0]           left_raw,
    input  wire logic [lir_pkg::SAMPLE_W-1:0]           right_raw,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0]         left_out,
    output logic signed [lir_pkg::SAMPLE_W-1:0]         right_out,
    output logic                                        run_last,
    output logic                                        clip_done
);

    localparam int POS_W  = lir_pkg::FC_W + FRAC_BITS;
    localparam int STEP_W = FRAC_BITS + 3;
    localparam int DIV_W  = lir_pkg::PROD_W;
    localparam int FC_W   = lir_pkg::FC_W;
    localparam int SMP_W  = lir_pkg::SAMPLE_W;
    localparam int TOT_W  = lir_pkg::TOTAL_W;
    localparam int CNT_W  = lir_pkg::CNT_W;

    // step = floor(rate * 2^FRAC_BITS / 48000) by reciprocal multiply; 48000 = 375 * 2^7 and
    // 375 < 2^9, so RATE_W + 9 shift bits keep the rounding error below one step of 1/375
    localparam int RECIP_SHIFT = lir_pkg::RATE_W + 9;
    localparam int RECIP_W     = FRAC_BITS + RECIP_SHIFT + 1 - $clog2(lir_pkg::OUT_RATE);
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (RECIP_SHIFT + FRAC_BITS)) + 64'(lir_pkg::OUT_RATE) - 64'd1) /
        64'(lir_pkg::OUT_RATE);
    localparam logic [RECIP_W-1:0] STEP_RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int SP_W        = lir_pkg::RATE_W + RECIP_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIVS = 5'b00010,
        S_DIVT = 5'b00100,
        S_EMA  = 5'b01000,
        S_EMB  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [lir_pkg::RATE_W-1:0] rate_reg, rate_next;
    logic                       stereo_reg, stereo_next;
    logic                       sixteen_reg, sixteen_next;
    logic [FC_W-1:0]            fcount_reg, fcount_next;

    // per-clip and per-frame state
    logic [FC_W-1:0]            frames_reg, frames_next;
    logic [FC_W-1:0]            k_reg, k_next;
    logic [FC_W-1:0]            km1_reg, km1_next;
    logic                       has_a_reg, has_a_next;
    logic                       last_reg, last_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [TOT_W-1:0]           left_reg, left_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [POS_W-1:0]           posn_reg, posn_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [lir_pkg::RATE_W-1:0] rcap_reg, rcap_next;
    logic [lir_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [SMP_W-1:0]    cur_l_reg, cur_l_next;
    logic signed [SMP_W-1:0]    cur_r_reg, cur_r_next;
    logic signed [SMP_W-1:0]    prev_l_reg, prev_l_next;
    logic signed [SMP_W-1:0]    prev_r_reg, prev_r_next;

    // output word
    logic                       ov_reg, ov_next;
    logic signed [SMP_W-1:0]    ol_reg, ol_next;
    logic signed [SMP_W-1:0]    or_reg, or_next;
    logic                       run_reg, run_next;
    logic                       done_reg, done_next;

    logic                       div_start;
    logic [DIV_W-1:0]           div_dividend;
    logic [lir_pkg::RATE_W-1:0] div_divisor;
    logic                       div_done;
    logic [DIV_W-1:0]           div_quot;

    logic [lir_pkg::RATE_W-1:0] rate_clamp;
    logic [SP_W-1:0]            step_prod;
    logic signed [SMP_W-1:0]    conv_l, conv_r;
    logic [FC_W-1:0]            pos_int, posn_int;
    logic [CNT_W-1:0]           n_inc;
    logic                       out_free;
    logic                       cond_a, cond_b, more_ok, cont_a, cont_b;
    logic                       emit;
    logic signed [SMP_W-1:0]    lane_a_l, lane_a_r;
    logic signed [SMP_W-1:0]    lane_y_l, lane_y_r;

    lir_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (lir_pkg::RATE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // left and right lanes; in the closing segment both ends are the current frame
    assign lane_a_l = (state_reg == S_EMB) ? cur_l_reg : prev_l_reg;
    assign lane_a_r = (state_reg == S_EMB) ? cur_r_reg : prev_r_reg;

    lir_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_l (
        .a    (lane_a_l),
        .b    (cur_l_reg),
        .frac (pos_reg[FRAC_BITS-1:0]),
        .y    (lane_y_l)
    );

    lir_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r (
        .a    (lane_a_r),
        .b    (cur_r_reg),
        .frac (pos_reg[FRAC_BITS-1:0]),
        .y    (lane_y_r)
    );

    always_comb
    begin
        rate_clamp = rate_reg;
        if (rate_reg < lir_pkg::RATE_MIN)
        begin
            rate_clamp = lir_pkg::RATE_MIN;
        end
        else if (rate_reg > lir_pkg::RATE_MAX)
        begin
            rate_clamp = lir_pkg::RATE_MAX;
        end
    end

    assign step_prod = SP_W'(rcap_reg) * SP_W'(STEP_RECIP);

    assign conv_l   = lir_pkg::to_s16(left_raw, sixteen_reg);
    assign conv_r   = stereo_reg ? lir_pkg::to_s16(right_raw, sixteen_reg) : conv_l;
    assign pos_int  = pos_reg[POS_W-1:FRAC_BITS];
    assign posn_int = posn_reg[POS_W-1:FRAC_BITS];
    assign n_inc    = n_reg + CNT_W'(1);
    assign out_free = !ov_reg || out_ready;

    // emit-now and lookahead conditions; lookahead decides run_last on the current word
    assign cond_a  = has_a_reg && (n_reg < lir_pkg::MAX_RESULTS) && (left_reg != '0)
                     && (pos_int <= km1_reg);
    assign cond_b  = (n_reg < lir_pkg::MAX_RESULTS) && (left_reg != '0) && (pos_int <= k_reg);
    assign more_ok = (n_inc < lir_pkg::MAX_RESULTS) && (left_reg > TOT_W'(1));
    assign cont_a  = (state_reg == S_EMA) && has_a_reg && more_ok && (posn_int <= km1_reg);
    assign cont_b  = last_reg && more_ok && (posn_int <= k_reg);

    always_comb
    begin
        state_next   = state_reg;
        rate_next    = rate_reg;
        stereo_next  = stereo_reg;
        sixteen_next = sixteen_reg;
        fcount_next  = fcount_reg;
        frames_next  = frames_reg;
        k_next       = k_reg;
        km1_next     = km1_reg;
        has_a_next   = has_a_reg;
        last_next    = last_reg;
        n_next       = n_reg;
        left_next    = left_reg;
        pos_next     = pos_reg;
        posn_next    = posn_reg;
        step_next    = step_reg;
        rcap_next    = rcap_reg;
        prod_next    = prod_reg;
        cur_l_next   = cur_l_reg;
        cur_r_next   = cur_r_reg;
        prev_l_next  = prev_l_reg;
        prev_r_next  = prev_r_reg;
        ov_next      = ov_reg;
        ol_next      = ol_reg;
        or_next      = or_reg;
        run_next     = run_reg;
        done_next    = done_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        emit         = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                lir_pkg::CFG_SOURCE_RATE: rate_next    = cfg_data[lir_pkg::RATE_W-1:0];
                lir_pkg::CFG_STEREO:      stereo_next  = cfg_data[0];
                lir_pkg::CFG_SIXTEEN_BIT: sixteen_next = cfg_data[0];
                lir_pkg::CFG_FRAME_COUNT: fcount_next  = cfg_data;
                default:                  rate_next    = rate_reg;
            endcase
        end

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // empty clip: word is taken and dropped
                if (in_valid && (fcount_reg != '0))
                begin
                    cur_l_next  = conv_l;
                    cur_r_next  = conv_r;
                    k_next      = frames_reg;
                    km1_next    = frames_reg - FC_W'(1);
                    has_a_next  = (frames_reg != '0);
                    last_next   = (frames_reg == fcount_reg - FC_W'(1));
                    n_next      = '0;
                    frames_next = (frames_reg == fcount_reg - FC_W'(1)) ?
                                  '0 : frames_reg + FC_W'(1);
                    if (frames_reg == '0)
                    begin
                        rcap_next  = rate_clamp;
                        prod_next  = lir_pkg::PROD_W'(fcount_reg) *
                                     lir_pkg::PROD_W'(lir_pkg::OUT_RATE);
                        state_next = S_DIVS;
                    end
                    else
                    begin
                        state_next = S_EMA;
                    end
                end
            end
            S_DIVS:
            begin
                step_next    = step_prod[RECIP_SHIFT +: STEP_W];
                div_start    = 1'b1;
                div_dividend = DIV_W'(prod_reg);
                div_divisor  = rcap_reg;
                state_next   = S_DIVT;
            end
            S_DIVT:
            begin
                if (div_done)
                begin
                    left_next  = div_quot[TOT_W-1:0];
                    pos_next   = '0;
                    posn_next  = POS_W'(step_reg);
                    state_next = S_EMA;
                end
            end
            S_EMA:
            begin
                if (cond_a)
                begin
                    if (out_free)
                    begin
                        emit     = 1'b1;
                        run_next = !(cont_a || cont_b);
                    end
                end
                else if (last_reg)
                begin
                    state_next = S_EMB;
                end
                else
                begin
                    prev_l_next = cur_l_reg;
                    prev_r_next = cur_r_reg;
                    state_next  = S_IDLE;
                end
            end
            S_EMB:
            begin
                if (cond_b)
                begin
                    if (out_free)
                    begin
                        emit     = 1'b1;
                        run_next = !cont_b;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            ov_next   = 1'b1;
            ol_next   = lane_y_l;
            or_next   = lane_y_r;
            done_next = (left_reg == TOT_W'(1));
            n_next    = n_inc;
            left_next = left_reg - TOT_W'(1);
            pos_next  = posn_reg;
            posn_next = posn_reg + POS_W'(step_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rate_reg    <= lir_pkg::RATE_RESET;
            stereo_reg  <= 1'b1;
            sixteen_reg <= 1'b1;
            fcount_reg  <= '0;
            frames_reg  <= '0;
            n_reg       <= '0;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rate_reg    <= rate_next;
            stereo_reg  <= stereo_next;
            sixteen_reg <= sixteen_next;
            fcount_reg  <= fcount_next;
            frames_reg  <= frames_next;
            n_reg       <= n_next;
            prev_l_reg  <= prev_l_next;
            prev_r_reg  <= prev_r_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        km1_reg   <= km1_next;
        has_a_reg <= has_a_next;
        last_reg  <= last_next;
        left_reg  <= left_next;
        pos_reg   <= pos_next;
        posn_reg  <= posn_next;
        step_reg  <= step_next;
        rcap_reg  <= rcap_next;
        prod_reg  <= prod_next;
        cur_l_reg <= cur_l_next;
        cur_r_reg <= cur_r_next;
        ol_reg    <= ol_next;
        or_reg    <= or_next;
        run_reg   <= run_next;
        done_reg  <= done_next;
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign left_out  = ol_reg;
    assign right_out = or_reg;
    assign run_last  = run_reg;
    assign clip_done = done_reg;

    // the final word of a clip must also close its frame's run
    a_clip_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && done_reg) |-> run_reg)
        else $error("clip_done word without run_last");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= lir_pkg::MAX_RESULTS)
        else $error("more results than the per-frame cap");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == S_DIVS) || (state_reg == S_DIVT)))
        else $error("divider finished outside the latch states");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (fcount_reg != '0)) |=> !in_ready)
        else $error("frame taken while the previous one is in flight");

    a_emit_only_if_free: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg != $past(n_reg) && n_reg != '0) |-> ov_reg)
        else $error("result count moved without a word in the output register");

endmodule

`default_nettype wire

// ===== dv/resampler_checker.sv =====
// Scoreboard for the 48 kHz linear-interpolation resampler: watches the cfg, in and out
// channels, predicts every output frame and compares field by field.
// Depends on lir_pkg for widths, limits and register indexes.

module resampler_checker
    import lir_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [FC_W-1:0]             cfg_data,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic [SAMPLE_W-1:0]         left_raw,
    input  wire logic [SAMPLE_W-1:0]         right_raw,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic signed [SAMPLE_W-1:0]  left_out,
    input  wire logic signed [SAMPLE_W-1:0]  right_out,
    input  wire logic                        run_last,
    input  wire logic                        clip_done,
    output int                               mismatches,
    output int                               pending,
    output int                               frames_checked
);

    localparam int POS_W = FC_W + FRAC_BITS;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last_of_input;
        logic                       clip_end;
    } out_frame_t;

    out_frame_t frames_due[$];
    out_frame_t batch[$];

    // register copies
    logic [RATE_W-1:0]          rate_reg;
    logic                       stereo_reg;
    logic                       sixteen_reg;
    logic [FC_W-1:0]            fcount_reg;

    // clip state
    logic [POS_W-1:0]           pos;
    logic [31:0]                step;
    logic [31:0]                total;
    logic [31:0]                emitted;
    logic [FC_W-1:0]            seen;
    logic signed [SAMPLE_W-1:0] held_l;
    logic signed [SAMPLE_W-1:0] held_r;

    function automatic logic signed [SAMPLE_W-1:0] widen(input logic [SAMPLE_W-1:0] raw,
                                                         input logic sixteen);
        int v;
        if (sixteen)
            v = int'(signed'(raw));
        else
            v = (int'(raw[7:0]) - 128) * 256;
        return SAMPLE_W'(v);
    endfunction

    // a + floor((b - a) * frac / 2^FRAC_BITS)
    function automatic logic signed [SAMPLE_W-1:0] blend(input logic signed [SAMPLE_W-1:0] a,
                                                         input logic signed [SAMPLE_W-1:0] b,
                                                         input logic [FRAC_BITS-1:0] frac);
        longint d;
        d = (longint'(b) - longint'(a)) * longint'({1'b0, frac});
        return SAMPLE_W'(longint'(a) + (d >>> FRAC_BITS));
    endfunction

    task automatic latch_clip();
        logic [RATE_W-1:0] r;
        r = rate_reg;
        if (r < RATE_MIN)
            r = RATE_MIN;
        if (r > RATE_MAX)
            r = RATE_MAX;
        step    = 32'((64'(r) << FRAC_BITS) / 64'(OUT_RATE));
        total   = 32'((64'(fcount_reg) * 64'(OUT_RATE)) / 64'(r));
        pos     = '0;
        emitted = '0;
    endtask

    task automatic emit_frame(input logic signed [SAMPLE_W-1:0] al,
                              input logic signed [SAMPLE_W-1:0] bl,
                              input logic signed [SAMPLE_W-1:0] ar,
                              input logic signed [SAMPLE_W-1:0] br);
        out_frame_t f;
        f.left          = blend(al, bl, pos[FRAC_BITS-1:0]);
        f.right         = blend(ar, br, pos[FRAC_BITS-1:0]);
        f.last_of_input = 1'b0;
        f.clip_end      = (emitted + 32'd1 == total);
        batch.push_back(f);
        emitted = emitted + 32'd1;
        pos     = pos + POS_W'(step);
    endtask

    task automatic resample_frame(input logic [SAMPLE_W-1:0] lraw,
                                  input logic [SAMPLE_W-1:0] rraw);
        logic signed [SAMPLE_W-1:0] cl;
        logic signed [SAMPLE_W-1:0] cr;
        logic [FC_W-1:0]            k;
        logic                       closing;
        out_frame_t                 f;
        if (fcount_reg == '0)
            return;
        if (seen == '0)
            latch_clip();
        cl      = widen(lraw, sixteen_reg);
        cr      = stereo_reg ? widen(rraw, sixteen_reg) : cl;
        k       = seen;
        closing = (k == fcount_reg - 1'b1);
        batch.delete();
        if (k != '0)
        begin
            while (batch.size() < int'(MAX_RESULTS) && emitted < total &&
                   pos[POS_W-1:FRAC_BITS] < k)
                emit_frame(held_l, cl, held_r, cr);
        end
        // last frame of the clip: next frame is clamped to this one
        if (closing)
        begin
            while (batch.size() < int'(MAX_RESULTS) && emitted < total &&
                   pos[POS_W-1:FRAC_BITS] <= k)
                emit_frame(cl, cl, cr, cr);
        end
        if (batch.size() > 0)
        begin
            f = batch[batch.size()-1];
            f.last_of_input = 1'b1;
            batch[batch.size()-1] = f;
        end
        foreach (batch[i])
            frames_due.push_back(batch[i]);
        if (closing)
        begin
            seen = '0;
        end
        else
        begin
            held_l = cl;
            held_r = cr;
            seen   = seen + 1'b1;
        end
    endtask

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_frame_t want;
        if (!rst_n)
        begin
            rate_reg       = RATE_RESET;
            stereo_reg     = 1'b1;
            sixteen_reg    = 1'b1;
            fcount_reg     = '0;
            seen           = '0;
            held_l         = '0;
            held_r         = '0;
            latch_clip();
            frames_due.delete();
            mismatches     = 0;
            frames_checked = 0;
            pending        = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SOURCE_RATE: rate_reg    = cfg_data[RATE_W-1:0];
                    CFG_STEREO:      stereo_reg  = cfg_data[0];
                    CFG_SIXTEEN_BIT: sixteen_reg = cfg_data[0];
                    CFG_FRAME_COUNT: fcount_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $display("%0t: output word with nothing expected (left %0d, right %0d)",
                             $time, left_out, right_out);
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("left_out", int'(want.left), int'(left_out));
                    check_field("right_out", int'(want.right), int'(right_out));
                    check_field("run_last", int'(want.last_of_input), int'(run_last));
                    check_field("clip_done", int'(want.clip_end), int'(clip_done));
                    frames_checked++;
                end
            end
            if (in_valid && in_ready)
                resample_frame(left_raw, right_raw);
            pending = frames_due.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the resampler testbench: clock, reset, cfg/in stimulus and out back-pressure.
// Depends on lir_pkg, linear_interp_resampler_48k_top and resampler_checker.

module testbench;
    import lir_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int SETTLE      = 200;      // divider pass plus a full burst of results
    localparam int CYCLE_LIMIT = 500000;

    logic                       clk;
    logic                       rst_n      = 1'b0;
    logic                       cfg_valid  = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index  = CFG_SOURCE_RATE;
    logic [FC_W-1:0]            cfg_data   = '0;
    logic                       in_valid   = 1'b0;
    logic                       in_ready;
    logic [SAMPLE_W-1:0]        left_raw   = '0;
    logic [SAMPLE_W-1:0]        right_raw  = '0;
    logic                       out_valid;
    logic                       out_ready  = 1'b1;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       run_last;
    logic                       clip_done;

    int mismatches;
    int pending;
    int frames_checked;
    int cycles       = 0;
    int frames_sent  = 0;
    int settings_cnt = 0;
    int gap_pct      = 20;
    int stall_pct    = 20;
    bit calm         = 1'b0;
    logic [FC_W-1:0] fc_now = '0;

    int common_rates[6] = '{8000, 11025, 22050, 44100, 96000, 48000};

    linear_interp_resampler_48k_top #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .left_raw  (left_raw),
        .right_raw (right_raw),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .left_out  (left_out),
        .right_out (right_out),
        .run_last  (run_last),
        .clip_done (clip_done)
    );

    resampler_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_raw       (left_raw),
        .right_raw      (right_raw),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_out       (left_out),
        .right_out      (right_out),
        .run_last       (run_last),
        .clip_done      (clip_done),
        .mismatches     (mismatches),
        .pending        (pending),
        .frames_checked (frames_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d output words still due", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // valid drops between writes, which keeps it from toggling within a step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FC_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_COUNT)
            fc_now = val;
        @(posedge clk);
    endtask

    // unused upper data bits are filled with noise
    task automatic configure(input logic [RATE_W-1:0] rate, input logic st,
                             input logic sx, input logic [FC_W-1:0] fc);
        write_reg(CFG_SOURCE_RATE, {10'($urandom), rate});
        write_reg(CFG_STEREO, {27'($urandom), st});
        write_reg(CFG_SIXTEEN_BIT, {27'($urandom), sx});
        write_reg(CFG_FRAME_COUNT, fc);
        settings_cnt++;
    endtask

    task automatic send_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
        in_valid  <= 1'b1;
        left_raw  <= l;
        right_raw <= r;
        do @(posedge clk); while (!in_ready);
        if (fc_now != '0)
            frames_sent++;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_random(input int n);
        repeat (n) send_frame(pick_sample(), pick_sample());
    endtask

    // drop valid, wait for every due word, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        logic [RATE_W-1:0] rate;
        logic [FC_W-1:0]   fc;
        int                part;
        int                goal;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // frame count is zero out of reset: words are dropped
        send_frame(16'h1234, 16'h8001);
        send_frame(16'hFFFF, 16'h0000);
        settle();

        // unity rate, 16-bit stereo, full-scale swings
        configure(18'd48000, 1'b1, 1'b1, 28'd3);
        send_frame(16'h8000, 16'h7FFF);
        send_frame(16'h7FFF, 16'h8000);
        send_frame(16'hFFFF, 16'h0000);
        settle();

        // slowest rate, 8-bit mono, byte extremes with noise in the high byte
        configure(RATE_MIN, 1'b0, 1'b0, 28'd2);
        send_frame(16'h00FF, 16'hAAAA);
        send_frame(16'hFF00, 16'h5555);
        settle();

        configure(RATE_MAX, 1'b1, 1'b1, 28'd5);
        send_frame(16'h0000, 16'hFFFF);
        send_frame(16'h8000, 16'h7FFF);
        send_frame(16'h7FFF, 16'h8000);
        send_random(2);
        settle();

        // out-of-range rates clamp; single-frame clip
        configure(18'd3999, 1'b1, 1'b0, 28'd1);
        send_random(1);
        settle();
        configure(18'h3FFFF, 1'b0, 1'b1, 28'd2);
        send_random(2);
        settle();

        // max frame count, lowered mid clip; rate rewrite must not touch the latched step
        configure(18'd0, 1'b1, 1'b1, 28'hFFFFFFF);
        send_random(3);
        settle();
        write_reg(CFG_FRAME_COUNT, 28'd5);
        write_reg(CFG_SOURCE_RATE, 28'd48000);
        send_random(2);
        settle();

        goal = frames_sent + 210;
        while (frames_sent < goal)
        begin
            if (frames_sent > goal - 30)
            begin
                calm = 1'b1;
            end
            else
            begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
            end

            case ($urandom_range(0, 9))
                0:       rate = RATE_W'($urandom_range(0, 3999));
                1:       rate = RATE_W'($urandom_range(192001, 262143));
                2, 3:    rate = RATE_W'(common_rates[$urandom_range(0, 5)]);
                default: rate = RATE_W'($urandom_range(4000, 192000));
            endcase
            case ($urandom_range(0, 15))
                0:       fc = '0;
                1:       fc = 28'd1;
                2:       fc = FC_W'($urandom_range(20, 40));
                default: fc = FC_W'($urandom_range(2, 12));
            endcase
            configure(rate, 1'($urandom), 1'($urandom), fc);

            if (fc == '0)
            begin
                send_random($urandom_range(1, 3));
            end
            else if (fc >= 28'd3 && $urandom_range(0, 4) == 0)
            begin
                // broken sequence: stop part way, change the format, rate and frame count
                part = $urandom_range(1, int'(fc) - 1);
                send_random(part);
                settle();
                fc = FC_W'(part + $urandom_range(1, 4));
                write_reg(CFG_STEREO, {27'($urandom), 1'($urandom)});
                write_reg(CFG_SIXTEEN_BIT, {27'($urandom), 1'($urandom)});
                write_reg(CFG_SOURCE_RATE, {10'($urandom), RATE_W'($urandom)});
                write_reg(CFG_FRAME_COUNT, fc);
                send_random(int'(fc) - part);
            end
            else
            begin
                send_random(int'(fc));
            end
            settle();
        end

        $display("Sent %0d source frames under %0d register settings, checked %0d output words.",
                 frames_sent, settings_cnt, frames_checked);
        $display("Covered 8/16-bit, mono/stereo, clamped rates and frame counts changed mid clip.");
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lir_pkg.sv
rtl/lir_lane.sv
rtl/lir_div.sv
rtl/linear_interp_resampler_48k_top.sv
dv/resampler_checker.sv
dv/testbench.sv
